@@ rtl/hdtf_pkg.sv @@
// ----------------------------------------------------------------------------
// hdtf_pkg: shared types and constants of the time frame deframer
// Operation codes passed from the classifier to the executing back end, the
// queue entry format and the byte-wide CRC-16 update.
// ----------------------------------------------------------------------------
package hdtf_pkg;

	localparam logic [7:0]  AddrByte = 8'h01;
	localparam logic [7:0]  LenMask  = 8'hFE;
	localparam logic [15:0] CrcPoly  = 16'h1021;
	localparam logic [15:0] CrcInit  = 16'hFFFF;
	// Highest position the byte counter reaches: header, 254 payload, trailer.
	localparam logic [8:0]  PosMax   = 9'd258;

	typedef enum logic [2:0] {
		OP_START,
		OP_CRC,
		OP_PAYLOAD,
		OP_TRAIL_HI,
		OP_CLOSE
	} op_t;

	typedef struct packed {
		op_t        op;
		logic [7:0] data;
		logic [1:0] ftype;
		logic [7:0] flen;
	} qent_t;

	function automatic logic [7:0] rev8(input logic [7:0] b);
		logic [7:0] r;
		for (int i = 0; i < 8; i++) begin
			r[7 - i] = b[i];
		end
		return r;
	endfunction

	// One byte of CRC-16, input reflected, MSB-first register.
	function automatic logic [15:0] crc_upd(input logic [15:0] c, input logic [7:0] b);
		logic [15:0] r;
		r = c ^ {rev8(b), 8'h00};
		for (int i = 0; i < 8; i++) begin
			if (r[15]) begin
				r = {r[14:0], 1'b0} ^ CrcPoly;
			end else begin
				r = {r[14:0], 1'b0};
			end
		end
		return r;
	endfunction

endpackage

@@ rtl/hdtf_if.sv @@
// ----------------------------------------------------------------------------
// hdtf_if: stream channels of the time frame deframer
// Received byte channel and result channel, both valid/ready.
// ----------------------------------------------------------------------------
interface hdtf_rx_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

interface hdtf_res_if;
	logic       valid;
	logic       ready;
	logic       result_kind;
	logic [7:0] payload_byte;
	logic [1:0] frame_type;
	logic [7:0] payload_length;
	logic       crc_good;
	logic       frame_end;

	modport source (output valid, output result_kind, output payload_byte,
		output frame_type, output payload_length, output crc_good,
		output frame_end, input ready);
	modport sink (input valid, input result_kind, input payload_byte,
		input frame_type, input payload_length, input crc_good,
		input frame_end, output ready);
endinterface

@@ rtl/hdtf_front.sv @@
// ----------------------------------------------------------------------------
// hdtf_front: frame position tracker and byte classifier
// Follows the frame structure byte by byte and queues one operation for each
// byte that matters to the back end.
// ----------------------------------------------------------------------------
module hdtf_front (
	input  logic          clk,
	input  logic          arst_n,
	hdtf_rx_if.sink       rx,
	input  logic          q_full,
	output logic          push,
	output hdtf_pkg::qent_t push_ent
);
	import hdtf_pkg::*;

	logic [8:0] pos_q;
	logic [7:0] len_q;
	logic [1:0] type_q;
	logic [8:0] pos_nx;
	logic [7:0] len_nx;
	logic [1:0] type_nx;
	logic       acc;
	logic       want;
	op_t        op;
	logic [3:0] nib;
	logic [8:0] trail_pos;

	assign rx.ready  = ~q_full;
	assign acc       = rx.valid & ~q_full;
	assign nib       = rx.rx_byte[7:4];
	assign trail_pos = {1'b0, len_q} + 9'd3;

	always_comb begin
		pos_nx  = pos_q;
		len_nx  = len_q;
		type_nx = type_q;
		want    = 1'b0;
		op      = OP_CRC;
		if (pos_q == 9'd0) begin
			len_nx  = 8'd0;
			type_nx = 2'd0;
			if (rx.rx_byte == AddrByte) begin
				want   = 1'b1;
				op     = OP_START;
				pos_nx = 9'd1;
			end
		end else if (pos_q == 9'd1) begin
			len_nx = rx.rx_byte & LenMask;
			want   = 1'b1;
			pos_nx = 9'd2;
		end else if (pos_q == 9'd2) begin
			if (nib[3:2] == 2'b00 && nib[1:0] != 2'b00) begin
				type_nx = nib[1:0] - 2'd1;
				want    = 1'b1;
				pos_nx  = 9'd3;
			end else begin
				pos_nx = 9'd0;
			end
		end else if (pos_q < trail_pos) begin
			want   = 1'b1;
			op     = OP_PAYLOAD;
			pos_nx = pos_q + 9'd1;
		end else if (pos_q == trail_pos) begin
			want   = 1'b1;
			op     = OP_TRAIL_HI;
			pos_nx = pos_q + 9'd1;
		end else begin
			want   = 1'b1;
			op     = OP_CLOSE;
			pos_nx = 9'd0;
		end
	end

	assign push           = acc & want;
	assign push_ent.op    = op;
	assign push_ent.data  = rx.rx_byte;
	assign push_ent.ftype = type_nx;
	assign push_ent.flen  = len_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= 9'd0;
			len_q  <= 8'd0;
			type_q <= 2'd0;
		end else if (acc) begin
			pos_q  <= pos_nx;
			len_q  <= len_nx;
			type_q <= type_nx;
		end
	end

`ifndef SYNTHESIS
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= PosMax)
		else $error("frame position beyond the longest frame");
`endif

endmodule

@@ rtl/hdtf_queue.sv @@
// ----------------------------------------------------------------------------
// hdtf_queue: two-entry queue between classifier and back end
// Lets the classifier keep taking bytes while the result side stalls.
// ----------------------------------------------------------------------------
module hdtf_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  hdtf_pkg::qent_t push_ent,
	output logic            full,
	input  logic            pop,
	output logic            head_valid,
	output hdtf_pkg::qent_t head_ent
);
	import hdtf_pkg::*;

	qent_t      ent_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;

	assign full       = (cnt_q == 2'd2);
	assign head_valid = (cnt_q != 2'd0);
	assign head_ent   = ent_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_q] <= push_ent;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push)
		else $error("push into a full queue");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid)
		else $error("pop from an empty queue");
`endif

endmodule

@@ rtl/hdtf_back.sv @@
// ----------------------------------------------------------------------------
// hdtf_back: CRC engine and result register
// Executes queued operations: runs the CRC, keeps the trailer high byte and
// loads payload and status results into the output register.
// ----------------------------------------------------------------------------
module hdtf_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            head_valid,
	input  hdtf_pkg::qent_t head_ent,
	output logic            pop,
	hdtf_res_if.source      res
);
	import hdtf_pkg::*;

	logic [15:0] crc_q;
	logic [7:0]  hi_q;
	logic        out_valid_q;
	logic        kind_q;
	logic [7:0]  pbyte_q;
	logic [1:0]  ftype_q;
	logic [7:0]  flen_q;
	logic        good_q;
	logic        emits;
	logic        slot_free;
	logic [15:0] crc_in;
	logic [15:0] crc_nx;
	logic [15:0] tx_crc;

	assign emits     = (head_ent.op == OP_PAYLOAD) || (head_ent.op == OP_CLOSE);
	assign slot_free = ~out_valid_q | res.ready;
	assign pop       = head_valid & (~emits | slot_free);
	assign crc_in    = (head_ent.op == OP_START) ? CrcInit : crc_q;
	assign crc_nx    = crc_upd(crc_in, head_ent.data);
	assign tx_crc    = {rev8(~hi_q), rev8(~head_ent.data)};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q       <= CrcInit;
			out_valid_q <= 1'b0;
		end else begin
			if (pop && emits) begin
				out_valid_q <= 1'b1;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end
			if (pop) begin
				case (head_ent.op)
					OP_START, OP_CRC, OP_PAYLOAD: begin
						crc_q <= crc_nx;
					end
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			case (head_ent.op)
				OP_TRAIL_HI: begin
					hi_q <= head_ent.data;
				end
				OP_PAYLOAD: begin
					kind_q  <= 1'b0;
					pbyte_q <= head_ent.data;
					ftype_q <= head_ent.ftype;
					flen_q  <= head_ent.flen;
					good_q  <= 1'b0;
				end
				OP_CLOSE: begin
					kind_q  <= 1'b1;
					pbyte_q <= 8'd0;
					ftype_q <= head_ent.ftype;
					flen_q  <= head_ent.flen;
					good_q  <= (tx_crc == crc_q);
				end
				default: begin
				end
			endcase
		end
	end

	assign res.valid          = out_valid_q;
	assign res.result_kind    = kind_q;
	assign res.payload_byte   = pbyte_q;
	assign res.frame_type     = ftype_q;
	assign res.payload_length = flen_q;
	assign res.crc_good       = good_q;
	assign res.frame_end      = kind_q;

`ifndef SYNTHESIS
	a_close_shown: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && head_ent.op == OP_CLOSE) |=> (out_valid_q && kind_q))
		else $error("frame close did not load a status result");
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && emits) |-> slot_free)
		else $error("result register overwritten before transfer");
`endif

endmodule

@@ rtl/hdlc_time_frame_deframer_crc_unit.sv @@
// ----------------------------------------------------------------------------
// hdlc_time_frame_deframer_crc_unit: time frame deframer with CRC-16 check
// Hunts for frames in a received byte stream, passes payload bytes on and
// closes each frame with a status result carrying type, length and CRC check.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Carries
//  -------  ---------  ------------------------------------------------------
//  rx       in         one received byte per transfer (rx_byte)
//  res      out        payload byte or frame status (kind, byte, type, length,
//                      crc_good, frame_end)
//
// One byte is taken in every cycle unless the queue is full; the classifier
// classifies each byte combinationally and the CRC engine in the back end
// updates a whole byte at once. A byte is first written into the two-entry
// queue; its result is loaded into the output register at the edge at which
// it leaves the queue, and that register drives res valid.
// A stalled result holds the back end only; the queue keeps absorbing bytes,
// and rx drops ready only once both queue entries are occupied.
// Reset clears the frame position (hunting for the address byte), the queue
// and the output valid, and loads the CRC register with all ones.
// ----------------------------------------------------------------------------
module hdlc_time_frame_deframer_crc_unit (
	input  logic        clk,
	input  logic        arst_n,
	hdtf_rx_if.sink     rx,
	hdtf_res_if.source  res
);
	import hdtf_pkg::*;

	// Classifier output into the queue.
	logic  push;
	qent_t push_ent;
	logic  q_full;

	// Queue head towards the back end.
	logic  head_valid;
	qent_t head_ent;
	logic  pop;

	// The front end tracks position, length and type and decides what each
	// byte means; bytes outside a frame never enter the queue.
	hdtf_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.rx       (rx),
		.q_full   (q_full),
		.push     (push),
		.push_ent (push_ent)
	);

	hdtf_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_ent   (push_ent),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_ent   (head_ent)
	);

	// The back end owns the CRC and the output register; it stalls only when
	// an operation that produces a result meets a full output register.
	hdtf_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_ent   (head_ent),
		.pop        (pop),
		.res        (res)
	);

endmodule
